// ===== rtl/dnsa_pkg.sv =====
// Package for the DNS A-record response parser.
// Holds the field widths, status codes and parse phase codes.
// No dependencies; every other file of the block imports it.
`default_nettype none

package dnsa_pkg;

  // Field widths of the byte and result channels.
  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 3;
  localparam int unsigned AddrW   = 32;
  localparam int unsigned TxidW   = 16;

  // Result status codes.
  localparam logic [StatusW-1:0] ST_FOUND     = 3'd0;
  localparam logic [StatusW-1:0] ST_BAD_ID    = 3'd1;
  localparam logic [StatusW-1:0] ST_BAD_FLAGS = 3'd2;
  localparam logic [StatusW-1:0] ST_BAD_LABEL = 3'd3;
  localparam logic [StatusW-1:0] ST_TRUNCATED = 3'd4;
  localparam logic [StatusW-1:0] ST_NO_A      = 3'd5;

  // Outcome register: zero while undecided, otherwise status plus one.
  localparam logic [StatusW-1:0] OUTC_NONE = 3'd0;

  // Parse phases.
  localparam int unsigned PhaseW = 4;
  localparam logic [PhaseW-1:0] PH_HEADER  = 4'd0;
  localparam logic [PhaseW-1:0] PH_Q_NAME  = 4'd1;
  localparam logic [PhaseW-1:0] PH_Q_LABEL = 4'd2;
  localparam logic [PhaseW-1:0] PH_Q_PTR   = 4'd3;
  localparam logic [PhaseW-1:0] PH_Q_FIX   = 4'd4;
  localparam logic [PhaseW-1:0] PH_A_NAME  = 4'd5;
  localparam logic [PhaseW-1:0] PH_A_LABEL = 4'd6;
  localparam logic [PhaseW-1:0] PH_A_PTR   = 4'd7;
  localparam logic [PhaseW-1:0] PH_A_FIX   = 4'd8;
  localparam logic [PhaseW-1:0] PH_A_SKIP  = 4'd9;
  localparam logic [PhaseW-1:0] PH_A_ADDR  = 4'd10;

  // Header and record layout.
  localparam logic [3:0] HDR_LAST_IDX   = 4'd11;
  localparam logic [3:0] QFIX_LAST_IDX  = 4'd3;
  localparam logic [3:0] AFIX_LAST_IDX  = 4'd9;
  localparam logic [TxidW-1:0] TXID_RESET = 16'hB10B;
  localparam logic [15:0] RR_TYPE_A     = 16'd1;
  localparam logic [15:0] RR_CLASS_IN   = 16'd1;
  localparam logic [15:0] RDLEN_IPV4    = 16'd4;
  localparam logic [5:0]  LABEL_MAX     = 6'd63;

  // Map a status onto the outcome register encoding.
  function automatic logic [StatusW-1:0] outcome_of(logic [StatusW-1:0] status);
    return status + 3'd1;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/dnsa_in_if.sv =====
// Byte channel of the DNS A-record response parser.
// Carries one message byte and its last-byte mark; depends on dnsa_pkg.
`default_nettype none

interface dnsa_in_if;
  import dnsa_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/dnsa_res_if.sv =====
// Result channel of the DNS A-record response parser.
// Carries the status and the captured address; depends on dnsa_pkg.
`default_nettype none

interface dnsa_res_if;
  import dnsa_pkg::*;

  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [AddrW-1:0]   ipv4_address;

  modport source (output valid, output status, output ipv4_address, input ready);
  modport sink   (input valid, input status, input ipv4_address, output ready);
endinterface

`default_nettype wire

// ===== rtl/dns_a_record_response_parser_core.sv =====
// DNS A-record response parser: one byte per item, one result per message.
// The result of a message is registered: it appears in the cycle after its last byte is taken.
// Throughput: one byte per cycle; the byte walker holds its whole state in registers.
// A byte waits while a result sits in the result register untaken; a result taken
// in the same cycle frees the register for the next byte.
// Reset (rst_ni low, asynchronous) clears the parse state and the result register
// and sets the expected transaction id to 0xB10B.
`default_nettype none

module dns_a_record_response_parser_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [dnsa_pkg::TxidW-1:0]  cfg_wdata_i,
  dnsa_in_if.sink                          in_i,
  dnsa_res_if.source                       res_o
);
  import dnsa_pkg::*;

  // Configuration register.
  logic [TxidW-1:0] txid_q;

  // Parse state.
  logic [PhaseW-1:0]  phase_q, phase_d;
  logic [3:0]         hdr_idx_q, hdr_idx_d;
  logic [15:0]        q_left_q, q_left_d;
  logic [15:0]        a_left_q, a_left_d;
  logic [5:0]         label_left_q, label_left_d;
  logic [3:0]         fix_idx_q, fix_idx_d;
  logic [15:0]        rtype_q, rtype_d;
  logic [15:0]        rclass_q, rclass_d;
  logic [15:0]        rdata_left_q, rdata_left_d;
  logic [AddrW-1:0]   addr_q, addr_d;
  logic [StatusW-1:0] outc_q, outc_d;

  // Result register.
  logic               res_valid_q;
  logic [StatusW-1:0] res_status_q, res_status_d;
  logic [AddrW-1:0]   res_addr_q, res_addr_d;

  logic             in_acc;
  logic [ByteW-1:0] b;
  logic             item_done;

  assign b         = in_i.data_byte;
  assign in_i.ready = !res_valid_q || res_o.ready;
  assign in_acc    = in_i.valid && in_i.ready;

  // Configuration write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      txid_q <= TXID_RESET;
    end else if (cfg_we_i) begin
      txid_q <= cfg_wdata_i;
    end
  end

  // Byte walker: next parse state for the byte at the input.
  always_comb begin
    phase_d      = phase_q;
    hdr_idx_d    = hdr_idx_q;
    q_left_d     = q_left_q;
    a_left_d     = a_left_q;
    label_left_d = label_left_q;
    fix_idx_d    = fix_idx_q;
    rtype_d      = rtype_q;
    rclass_d     = rclass_q;
    rdata_left_d = rdata_left_q;
    addr_d       = addr_q;
    outc_d       = outc_q;
    item_done    = 1'b0;

    if (outc_q == OUTC_NONE) begin
      unique case (phase_q) inside
        PH_HEADER: begin
          case (hdr_idx_q)
            4'd0: rtype_d = {b, 8'h00};
            4'd1: begin
              rtype_d = {rtype_q[15:8], b};
              if ({rtype_q[15:8], b} != txid_q) outc_d = outcome_of(ST_BAD_ID);
            end
            4'd2: if (!b[7]) outc_d = outcome_of(ST_BAD_FLAGS);
            4'd3: if (b[3:0] != 4'h0) outc_d = outcome_of(ST_BAD_FLAGS);
            4'd4: q_left_d = {b, 8'h00};
            4'd5: q_left_d = {q_left_q[15:8], b};
            4'd6: a_left_d = {b, 8'h00};
            4'd7: a_left_d = {a_left_q[15:8], b};
            default: ;
          endcase
          // The index stops where an error is decided.
          if (outc_d == OUTC_NONE) begin
            if (hdr_idx_q >= HDR_LAST_IDX) begin
              rtype_d   = 16'h0000;
              item_done = 1'b1;
            end else begin
              hdr_idx_d = hdr_idx_q + 4'd1;
            end
          end
        end
        PH_Q_NAME, PH_A_NAME: begin
          if (b[7:6] == 2'b11) begin
            phase_d = (phase_q == PH_Q_NAME) ? PH_Q_PTR : PH_A_PTR;
          end else if (b == 8'h00) begin
            phase_d   = (phase_q == PH_Q_NAME) ? PH_Q_FIX : PH_A_FIX;
            fix_idx_d = 4'd0;
          end else if (b > {2'b00, LABEL_MAX}) begin
            outc_d = outcome_of(ST_BAD_LABEL);
          end else begin
            label_left_d = b[5:0];
            phase_d      = (phase_q == PH_Q_NAME) ? PH_Q_LABEL : PH_A_LABEL;
          end
        end
        PH_Q_LABEL, PH_A_LABEL: begin
          label_left_d = label_left_q - 6'd1;
          if (label_left_q == 6'd1) begin
            phase_d = (phase_q == PH_Q_LABEL) ? PH_Q_NAME : PH_A_NAME;
          end
        end
        PH_Q_PTR, PH_A_PTR: begin
          phase_d   = (phase_q == PH_Q_PTR) ? PH_Q_FIX : PH_A_FIX;
          fix_idx_d = 4'd0;
        end
        PH_Q_FIX: begin
          if (fix_idx_q >= QFIX_LAST_IDX) begin
            q_left_d  = q_left_q - 16'd1;
            item_done = 1'b1;
          end else begin
            fix_idx_d = fix_idx_q + 4'd1;
          end
        end
        PH_A_FIX: begin
          case (fix_idx_q)
            4'd0: rtype_d      = {b, 8'h00};
            4'd1: rtype_d      = {rtype_q[15:8], b};
            4'd2: rclass_d     = {b, 8'h00};
            4'd3: rclass_d     = {rclass_q[15:8], b};
            4'd8: rdata_left_d = {b, 8'h00};
            4'd9: rdata_left_d = {rdata_left_q[15:8], b};
            default: ;
          endcase
          if (fix_idx_q < AFIX_LAST_IDX) begin
            fix_idx_d = fix_idx_q + 4'd1;
          end else if (rtype_d == RR_TYPE_A && rclass_d == RR_CLASS_IN &&
                       rdata_left_d == RDLEN_IPV4) begin
            addr_d  = '0;
            phase_d = PH_A_ADDR;
          end else if (rdata_left_d == 16'd0) begin
            a_left_d  = a_left_q - 16'd1;
            item_done = 1'b1;
          end else begin
            phase_d = PH_A_SKIP;
          end
        end
        PH_A_SKIP: begin
          rdata_left_d = rdata_left_q - 16'd1;
          if (rdata_left_q == 16'd1) begin
            a_left_d  = a_left_q - 16'd1;
            item_done = 1'b1;
          end
        end
        PH_A_ADDR: begin
          addr_d       = {addr_q[AddrW-ByteW-1:0], b};
          rdata_left_d = rdata_left_q - 16'd1;
          if (rdata_left_q == 16'd1) outc_d = outcome_of(ST_FOUND);
        end
        default: begin
          phase_d      = PH_HEADER;
          hdr_idx_d    = 4'd0;
          q_left_d     = 16'd0;
          a_left_d     = 16'd0;
          label_left_d = 6'd0;
          fix_idx_d    = 4'd0;
          rtype_d      = 16'd0;
          rclass_d     = 16'd0;
          rdata_left_d = 16'd0;
          addr_d       = '0;
          outc_d       = OUTC_NONE;
        end
      endcase

      // Move on to the next question or answer, or decide that none matched.
      if (item_done) begin
        fix_idx_d = 4'd0;
        if (q_left_d != 16'd0) begin
          phase_d = PH_Q_NAME;
        end else if (a_left_d != 16'd0) begin
          phase_d = PH_A_NAME;
        end else begin
          outc_d = outcome_of(ST_NO_A);
        end
      end
    end
  end

  // Result of a message, formed from the state after its last byte.
  always_comb begin
    res_status_d = (outc_d != OUTC_NONE) ? (outc_d - 3'd1) : ST_TRUNCATED;
    res_addr_d   = (res_status_d == ST_FOUND) ? addr_d : '0;
  end

  // Parse state registers; a last byte returns them to the start of a message.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HEADER;
      hdr_idx_q    <= 4'd0;
      q_left_q     <= 16'd0;
      a_left_q     <= 16'd0;
      label_left_q <= 6'd0;
      fix_idx_q    <= 4'd0;
      rtype_q      <= 16'd0;
      rclass_q     <= 16'd0;
      rdata_left_q <= 16'd0;
      addr_q       <= '0;
      outc_q       <= OUTC_NONE;
    end else if (in_acc) begin
      if (in_i.last_byte) begin
        phase_q      <= PH_HEADER;
        hdr_idx_q    <= 4'd0;
        q_left_q     <= 16'd0;
        a_left_q     <= 16'd0;
        label_left_q <= 6'd0;
        fix_idx_q    <= 4'd0;
        rtype_q      <= 16'd0;
        rclass_q     <= 16'd0;
        rdata_left_q <= 16'd0;
        addr_q       <= '0;
        outc_q       <= OUTC_NONE;
      end else begin
        phase_q      <= phase_d;
        hdr_idx_q    <= hdr_idx_d;
        q_left_q     <= q_left_d;
        a_left_q     <= a_left_d;
        label_left_q <= label_left_d;
        fix_idx_q    <= fix_idx_d;
        rtype_q      <= rtype_d;
        rclass_q     <= rclass_d;
        rdata_left_q <= rdata_left_d;
        addr_q       <= addr_d;
        outc_q       <= outc_d;
      end
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (in_acc && in_i.last_byte) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_status_q <= ST_FOUND;
      res_addr_q   <= '0;
    end else if (in_acc && in_i.last_byte) begin
      res_status_q <= res_status_d;
      res_addr_q   <= res_addr_d;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.status       = res_status_q;
  assign res_o.ipv4_address = res_addr_q;

  // A last byte always brings the parser back to the header phase with a result.
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.last_byte |=> phase_q == PH_HEADER && hdr_idx_q == 4'd0 &&
                                 outc_q == OUTC_NONE && res_o.valid)
    else $error("parser did not restart after the last byte");

  // The address is zero for every status other than found.
  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.status != ST_FOUND |-> res_o.ipv4_address == '0)
    else $error("address is not zero on a failed lookup");

  // Once decided, the walker ignores the rest of the message.
  a_decided_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outc_q != OUTC_NONE && in_acc && !in_i.last_byte |=>
      phase_q == $past(phase_q) && outc_q == $past(outc_q) && addr_q == $past(addr_q))
    else $error("parse state changed after the outcome was decided");

endmodule

`default_nettype wire

// ===== sim/dnsa_reply_checker.sv =====
// Scoreboard for the DNS A-record response parser: it follows each accepted byte through
// its own copy of the parse state and compares every result against the oldest prediction.
// Depends on dnsa_pkg and the dnsa_in_if / dnsa_res_if channel interfaces.
module dnsa_reply_checker
  import dnsa_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [TxidW-1:0] cfg_wdata_i,
  dnsa_in_if                    byte_mon,
  dnsa_res_if                   res_mon,
  output int unsigned           faults_o,
  output int unsigned           results_due_o
);

  localparam int unsigned ShownFaults = 10;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [AddrW-1:0]   addr;
  } lookup_t;

  // Results predicted but not yet seen on the result channel, oldest first.
  lookup_t lookups_due[$];

  // Shadow of the transaction id register and of the byte walker.
  logic [TxidW-1:0]   txid_want;
  logic [PhaseW-1:0]  walk_phase;
  logic [3:0]         hdr_pos;
  logic [15:0]        questions_to_go;
  logic [15:0]        answers_to_go;
  logic [5:0]         label_to_go;
  logic [3:0]         fix_pos;
  logic [15:0]        rr_type;
  logic [15:0]        rr_class;
  logic [15:0]        rdata_to_go;
  logic [AddrW-1:0]   addr_shift;
  logic [StatusW-1:0] verdict;

  function automatic void clear_walk();
    walk_phase      = PH_HEADER;
    hdr_pos         = '0;
    questions_to_go = '0;
    answers_to_go   = '0;
    label_to_go     = '0;
    fix_pos         = '0;
    rr_type         = '0;
    rr_class        = '0;
    rdata_to_go     = '0;
    addr_shift      = '0;
    verdict         = OUTC_NONE;
  endfunction

  // Move on to the next question, else the next answer, else give up on finding an A record.
  function automatic void begin_next_entry();
    fix_pos = '0;
    if (questions_to_go != 16'd0) begin
      walk_phase = PH_Q_NAME;
    end else if (answers_to_go != 16'd0) begin
      walk_phase = PH_A_NAME;
    end else begin
      verdict = ST_NO_A + 3'd1;
    end
  endfunction

  // First byte of a label: pointer, end of name, bad length or a label length.
  function automatic void take_name_byte(input logic [ByteW-1:0] b,
                                         input logic [PhaseW-1:0] to_label,
                                         input logic [PhaseW-1:0] to_ptr,
                                         input logic [PhaseW-1:0] to_fix);
    if (b[7:6] == 2'b11) begin
      walk_phase = to_ptr;
    end else if (b == 8'h00) begin
      walk_phase = to_fix;
      fix_pos    = '0;
    end else if (b > {2'b00, LABEL_MAX}) begin
      verdict = ST_BAD_LABEL + 3'd1;
    end else begin
      label_to_go = b[5:0];
      walk_phase  = to_label;
    end
  endfunction

  function automatic void take_byte(input logic [ByteW-1:0] b);
    case (walk_phase)
      PH_HEADER: begin
        case (hdr_pos)
          4'd0: rr_type = {b, 8'h00};
          4'd1: begin
            rr_type = {rr_type[15:8], b};
            if (rr_type != txid_want) verdict = ST_BAD_ID + 3'd1;
          end
          4'd2: if (!b[7]) verdict = ST_BAD_FLAGS + 3'd1;
          4'd3: if (b[3:0] != 4'h0) verdict = ST_BAD_FLAGS + 3'd1;
          4'd4: questions_to_go = {b, 8'h00};
          4'd5: questions_to_go = {questions_to_go[15:8], b};
          4'd6: answers_to_go = {b, 8'h00};
          4'd7: answers_to_go = {answers_to_go[15:8], b};
          default: ;
        endcase
        if (verdict == OUTC_NONE) begin
          if (hdr_pos >= HDR_LAST_IDX) begin
            rr_type = '0;
            begin_next_entry();
          end else begin
            hdr_pos = hdr_pos + 4'd1;
          end
        end
      end
      PH_Q_NAME: take_name_byte(b, PH_Q_LABEL, PH_Q_PTR, PH_Q_FIX);
      PH_A_NAME: take_name_byte(b, PH_A_LABEL, PH_A_PTR, PH_A_FIX);
      PH_Q_LABEL, PH_A_LABEL: begin
        label_to_go = label_to_go - 6'd1;
        if (label_to_go == 6'd0) begin
          walk_phase = (walk_phase == PH_Q_LABEL) ? PH_Q_NAME : PH_A_NAME;
        end
      end
      PH_Q_PTR, PH_A_PTR: begin
        walk_phase = (walk_phase == PH_Q_PTR) ? PH_Q_FIX : PH_A_FIX;
        fix_pos    = '0;
      end
      PH_Q_FIX: begin
        if (fix_pos >= QFIX_LAST_IDX) begin
          questions_to_go = questions_to_go - 16'd1;
          begin_next_entry();
        end else begin
          fix_pos = fix_pos + 4'd1;
        end
      end
      PH_A_FIX: begin
        // Type, class and rdlength are gathered; the TTL bytes are skipped.
        case (fix_pos)
          4'd0: rr_type = {b, 8'h00};
          4'd1: rr_type = {rr_type[15:8], b};
          4'd2: rr_class = {b, 8'h00};
          4'd3: rr_class = {rr_class[15:8], b};
          4'd8: rdata_to_go = {b, 8'h00};
          4'd9: rdata_to_go = {rdata_to_go[15:8], b};
          default: ;
        endcase
        if (fix_pos < AFIX_LAST_IDX) begin
          fix_pos = fix_pos + 4'd1;
        end else if (rr_type == RR_TYPE_A && rr_class == RR_CLASS_IN &&
                     rdata_to_go == RDLEN_IPV4) begin
          addr_shift = '0;
          walk_phase = PH_A_ADDR;
        end else if (rdata_to_go == 16'd0) begin
          answers_to_go = answers_to_go - 16'd1;
          begin_next_entry();
        end else begin
          walk_phase = PH_A_SKIP;
        end
      end
      PH_A_SKIP: begin
        rdata_to_go = rdata_to_go - 16'd1;
        if (rdata_to_go == 16'd0) begin
          answers_to_go = answers_to_go - 16'd1;
          begin_next_entry();
        end
      end
      PH_A_ADDR: begin
        addr_shift  = {addr_shift[AddrW-9:0], b};
        rdata_to_go = rdata_to_go - 16'd1;
        if (rdata_to_go == 16'd0) verdict = ST_FOUND + 3'd1;
      end
      default: clear_walk();
    endcase
  endfunction

  // Results are compared before the byte of the same edge is predicted: a result
  // always belongs to a byte taken at an earlier edge.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    lookup_t got;
    lookup_t want;
    logic [StatusW-1:0] outcome;
    if (!rst_ni) begin
      txid_want = TXID_RESET;
      clear_walk();
      lookups_due.delete();
    end else begin
      if (cfg_we_i) txid_want = cfg_wdata_i;

      if (res_mon.valid && res_mon.ready) begin
        got.status = res_mon.status;
        got.addr   = res_mon.ipv4_address;
        if (lookups_due.size() == 0) begin
          if (faults_o < ShownFaults) begin
            $display("unexpected result: status %0d address %h", got.status, got.addr);
          end
          faults_o++;
        end else begin
          want = lookups_due.pop_front();
          if (got.status !== want.status || got.addr !== want.addr) begin
            if (faults_o < ShownFaults) begin
              $display("result mismatch: status exp %0d got %0d, address exp %h got %h",
                       want.status, got.status, want.addr, got.addr);
            end
            faults_o++;
          end
        end
      end

      if (byte_mon.valid && byte_mon.ready) begin
        if (verdict == OUTC_NONE) take_byte(byte_mon.data_byte);
        if (byte_mon.last_byte) begin
          outcome   = (verdict != OUTC_NONE) ? verdict - 3'd1 : ST_TRUNCATED;
          want.status = outcome;
          want.addr   = (outcome == ST_FOUND) ? addr_shift : '0;
          lookups_due.push_back(want);
          clear_walk();
        end
      end
    end
    results_due_o = lookups_due.size();
  end

endmodule

// ===== sim/dns_a_record_response_parser_core_tb.sv =====
// Testbench top for the DNS A-record response parser: builds DNS response messages,
// drives them byte by byte, throttles the result side and gives the verdict.
// Depends on dnsa_pkg, the channel interfaces, dnsa_reply_checker and the parser core.
module dns_a_record_response_parser_core_tb;
  import dnsa_pkg::*;

  localparam int unsigned HoldOffCycles = 60;
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned StallLimit    = 1000;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we;
  logic [TxidW-1:0] cfg_wdata;

  dnsa_in_if  byte_if ();
  dnsa_res_if res_if ();

  int unsigned      fault_count;
  int unsigned      results_due;
  int unsigned      src_idle_pct = 34;
  int unsigned      snk_idle_pct = 67;
  bit               hold_off_req = 1'b0;
  logic [TxidW-1:0] txid_now;
  logic [ByteW-1:0] msg_bytes[$];
  int unsigned      name_marks[$];
  int unsigned      phase_bytes;
  int unsigned      phase_results;
  int unsigned      quiet_cycles = 0;

  dns_a_record_response_parser_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (byte_if),
    .res_o       (res_if)
  );

  dnsa_reply_checker reply_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .byte_mon      (byte_if),
    .res_mon       (res_if),
    .faults_o      (fault_count),
    .results_due_o (results_due)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Result side: random back-pressure, or a long hold-off when the stimulus asks for one.
  initial begin : result_drain
    int unsigned stall_left;
    stall_left   = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HoldOffCycles;
      end
      if (stall_left != 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Watchdog: ends the run when neither channel moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (byte_if.valid && byte_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Message building: everything is appended to msg_bytes.
  function automatic void put8(input logic [ByteW-1:0] b);
    msg_bytes.push_back(b);
  endfunction

  function automatic void put16(input logic [15:0] v);
    put8(v[15:8]);
    put8(v[7:0]);
  endfunction

  function automatic void put_random(input int unsigned n);
    repeat (n) put8(8'($urandom));
  endfunction

  // Starts a new message with a valid header carrying the current id.
  function automatic void put_header(input logic [15:0] qd, input logic [15:0] an);
    msg_bytes.delete();
    name_marks.delete();
    put16(txid_now);
    put8({1'b1, 7'($urandom)});
    put8({4'($urandom), 4'h0});
    put16(qd);
    put16(an);
    put16(16'($urandom));
    put16(16'($urandom));
  endfunction

  // Shape 0 is the root name, 1 a pointer, 2 labels then root, 3 labels then a pointer.
  function automatic void put_name(input int unsigned shape);
    int unsigned len;
    name_marks.push_back(msg_bytes.size());
    if (shape >= 2) begin
      repeat ($urandom_range(3, 1)) begin
        len = ($urandom_range(15) == 0) ? $urandom_range(63, 1) : $urandom_range(5, 1);
        put8(8'(len));
        put_random(len);
      end
    end
    if (shape[0]) begin
      put8({2'b11, 6'($urandom)});
      put8(8'($urandom));
    end else begin
      put8(8'h00);
    end
  endfunction

  function automatic void put_rr_head(input logic [15:0] t, input logic [15:0] c,
                                      input logic [15:0] len);
    put16(t);
    put16(c);
    put16(16'($urandom));
    put16(16'($urandom));
    put16(len);
  endfunction

  // An answer record that either is the A record sought or just misses it.
  function automatic void put_answer(input bit match);
    logic [15:0] t;
    logic [15:0] c;
    logic [15:0] len;
    put_name($urandom_range(3));
    if (match) begin
      t   = RR_TYPE_A;
      c   = RR_CLASS_IN;
      len = RDLEN_IPV4;
    end else begin
      case ($urandom_range(3))
        0:       t = RR_TYPE_A;
        1:       t = 16'd5;
        2:       t = 16'd28;
        default: t = 16'($urandom);
      endcase
      c   = ($urandom_range(2) == 0) ? 16'($urandom) : RR_CLASS_IN;
      len = 16'($urandom_range(6));
      if (t == RR_TYPE_A && c == RR_CLASS_IN && len == RDLEN_IPV4) len = 16'd5;
    end
    put_rr_head(t, c, len);
    put_random(len);
  endfunction

  task automatic send_byte(input logic [ByteW-1:0] b, input logic l);
    while ($urandom_range(99) < src_idle_pct) begin
      byte_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    byte_if.valid     <= 1'b1;
    byte_if.data_byte <= b;
    byte_if.last_byte <= l;
    @(posedge clk_i);
    while (!byte_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_message();
    int unsigned n;
    n = msg_bytes.size();
    for (int unsigned i = 0; i < n; i++) send_byte(msg_bytes[i], i == n - 1);
    phase_bytes += n;
    phase_results++;
  endtask

  // Stop offering bytes and wait until every predicted result has been taken.
  task automatic settle();
    byte_if.valid <= 1'b0;
    while (results_due != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_txid(input logic [TxidW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    txid_now   = v;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  // Mostly well-formed messages with random content, some damaged on purpose, a few noise.
  task automatic run_random(input int unsigned byte_goal, input int unsigned result_goal);
    int unsigned qd;
    int unsigned an;
    int unsigned hit;
    int unsigned pick;
    int unsigned idx;
    phase_bytes   = 0;
    phase_results = 0;
    while (phase_bytes < byte_goal || phase_results < result_goal) begin
      if ($urandom_range(19) == 0) begin
        msg_bytes.delete();
        put_random($urandom_range(20, 1));
      end else begin
        qd  = $urandom_range(2);
        an  = $urandom_range(3);
        hit = $urandom_range(an);
        put_header(16'(qd), 16'(an));
        repeat (qd) begin
          put_name($urandom_range(3));
          put16(16'($urandom));
          put16(16'($urandom));
        end
        for (int unsigned k = 1; k <= an; k++) put_answer(k == hit);
        if ($urandom_range(3) == 0) put_random($urandom_range(4, 1));

        pick = $urandom_range(99);
        if (pick < 6) begin
          // Wrong transaction id.
          idx = $urandom_range(1);
          msg_bytes[idx] = msg_bytes[idx] ^ 8'(1 << $urandom_range(7));
        end else if (pick < 10) begin
          msg_bytes[2] = msg_bytes[2] & 8'h7F;
        end else if (pick < 14) begin
          msg_bytes[3] = msg_bytes[3] | 8'($urandom_range(15, 1));
        end else if (pick < 20 && name_marks.size() != 0) begin
          // Label length outside 1..63 that is not a pointer either.
          idx = name_marks[$urandom_range(name_marks.size() - 1)];
          msg_bytes[idx] = 8'($urandom_range(191, 64));
        end else if (pick < 24) begin
          // Arbitrary question or answer count.
          msg_bytes[4 + $urandom_range(3)] = 8'($urandom);
        end else if (pick < 38) begin
          repeat ($urandom_range(msg_bytes.size() - 1)) void'(msg_bytes.pop_back());
        end else if (pick < 44) begin
          idx = $urandom_range(msg_bytes.size() - 1);
          msg_bytes[idx] = 8'($urandom);
        end
      end
      send_message();
    end
  endtask

  initial begin : stimulus
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    byte_if.valid     = 1'b0;
    byte_if.data_byte = '0;
    byte_if.last_byte = 1'b0;
    txid_now          = TXID_RESET;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // A lone byte cannot hold a header.
    msg_bytes = '{8'hFF};
    send_message();
    // Wrong id; the flags byte after it must not matter.
    msg_bytes = '{~txid_now[15:8], txid_now[7:0], 8'h00};
    send_message();
    // Response bit clear.
    msg_bytes = '{txid_now[15:8], txid_now[7:0], 8'h7F, 8'h00};
    send_message();
    // Nonzero rcode.
    msg_bytes = '{txid_now[15:8], txid_now[7:0], 8'hFF, 8'h0F};
    send_message();
    // No questions and no answers, then a trailing byte.
    put_header(16'd0, 16'd0);
    put8(8'h00);
    send_message();
    // Header cut one byte short.
    put_header(16'd0, 16'd0);
    void'(msg_bytes.pop_back());
    send_message();
    // Empty record and five-byte A record skipped before an all-ones address.
    put_header(16'd1, 16'd3);
    put_name(2);
    put16(RR_TYPE_A);
    put16(RR_CLASS_IN);
    put_name(1);
    put_rr_head(16'd5, RR_CLASS_IN, 16'd0);
    put_name(0);
    put_rr_head(RR_TYPE_A, RR_CLASS_IN, 16'd5);
    put_random(5);
    put_name(3);
    put_rr_head(RR_TYPE_A, RR_CLASS_IN, RDLEN_IPV4);
    put16(16'hFFFF);
    put16(16'hFFFF);
    send_message();
    // All-zero address, with trailing bytes that must be ignored.
    put_header(16'd0, 16'd1);
    put_name(1);
    put_rr_head(RR_TYPE_A, RR_CLASS_IN, RDLEN_IPV4);
    put16(16'h0000);
    put16(16'h0000);
    put16(16'hABCD);
    send_message();
    // Message cut inside the address.
    put_header(16'd0, 16'd1);
    put_name(0);
    put_rr_head(RR_TYPE_A, RR_CLASS_IN, RDLEN_IPV4);
    put_random(3);
    send_message();
    // Smallest bad label length in a question name.
    put_header(16'd1, 16'd0);
    put8(8'h40);
    put8(8'h00);
    send_message();
    // Largest bad label length after a label in an answer name.
    put_header(16'd0, 16'd1);
    put8(8'd3);
    put_random(3);
    put8(8'hBF);
    put8(8'h00);
    send_message();
    // Longest label, then an address record of the wrong class.
    put_header(16'd0, 16'd1);
    put8(8'd63);
    put_random(63);
    put8(8'h00);
    put_rr_head(RR_TYPE_A, 16'd3, RDLEN_IPV4);
    put_random(4);
    send_message();

    run_random(180, 12);
    settle();

    // Id zero; now the sender is the slow side.
    src_idle_pct = 67;
    snk_idle_pct = 34;
    write_txid(16'h0000);
    run_random(120, 6);
    // The sender waits here until every result has come back.
    settle();
    run_random(120, 6);
    settle();

    // All-ones id at full rate; first the result side holds off while short messages
    // keep coming, so the block fills up and stalls its byte input.
    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_txid(16'hFFFF);
    @(posedge clk_i);
    hold_off_req = 1'b1;
    @(negedge clk_i);
    repeat (10) begin
      msg_bytes = '{8'($urandom), 8'($urandom)};
      send_message();
    end
    run_random(240, 14);
    settle();

    write_txid(16'($urandom));
    run_random(240, 14);
    settle();

    if (fault_count == 0 && results_due == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
